// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, reset values and register indexes of the sync stuffed
// frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W       = 8;
    localparam int POS_W        = 16;
    localparam int HEADER_BYTES = 2;

    localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'd126;
    localparam logic [POS_W-1:0]  CAPACITY_RESET = 16'd256;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SYNC_VALUE       = 1'b0,
        CFG_PAYLOAD_CAPACITY = 1'b1
    } t_cfg_index;

endpackage

// ===== design/sync_stuffed_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// sync_stuffed_frame_decoder
// Byte-wide deframer for sync-delimited, byte-stuffed frames with a
// two-byte little-endian length header.
// ----------------------------------------------------------------------------
// The decoder takes one input transaction per clock and returns at most one
// result transaction for it, registered in the cycle after acceptance. Each transaction is
// either a received byte or a rearm command. After rearm or reset the block
// hunts for the sync byte, then reads a little-endian 16-bit length and that
// many payload bytes. A sync byte inside header or payload is sent doubled; a
// lone sync followed by another byte aborts the frame (a result with aborted
// set) and that byte becomes the first header byte of a new frame. Every
// destuffed payload byte is reported with its offset, and the final one has
// last set; a zero length completes at the end of the header. Once the
// payload reaches payload_capacity without completing, a result with overrun
// set is given and further bytes are dropped until rearm, as they are after
// a completed frame. Sustained rate is one transaction per cycle: the whole
// decision is made combinationally from the phase, position and header
// registers, and the result register is reloaded in the same cycle it is
// drained, so transactions flow back to back while results are taken. A
// result left waiting holds off the input until it is taken, whether or not
// the next transaction would give a result. The configuration port is always
// ready and should be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module sync_stuffed_frame_decoder
    import sfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_index        i_cfg_index,
    input  logic [POS_W-1:0]  i_cfg_data,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [BYTE_W-1:0] i_rx_byte,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_byte_valid,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [POS_W-1:0]  o_byte_offset,
    output logic              o_last,
    output logic              o_aborted,
    output logic              o_overrun,
    output logic [POS_W-1:0]  o_frame_length
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_HEADER_SYNC,
        PH_PAYLOAD,
        PH_PAYLOAD_SYNC,
        PH_COMPLETE,
        PH_OVERRUN
    } t_phase;

    // Configuration registers.
    logic [BYTE_W-1:0] r_sync;
    logic [POS_W-1:0]  r_capacity;

    // Frame state.
    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_len_lo, n_len_lo;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;

    // Result register.
    logic              r_out_valid;
    logic              r_byte_valid;
    logic [BYTE_W-1:0] r_data_byte;
    logic [POS_W-1:0]  r_byte_offset;
    logic              r_last;
    logic              r_aborted;
    logic              r_overrun;
    logic [POS_W-1:0]  r_frame_length;

    // Next result.
    logic              n_out_valid;
    logic              n_byte_valid;
    logic [BYTE_W-1:0] n_data_byte;
    logic [POS_W-1:0]  n_byte_offset;
    logic              n_last;
    logic              n_aborted;
    logic              n_overrun;
    logic [POS_W-1:0]  n_frame_length;

    logic              w_in_acc;
    logic              w_is_sync;
    logic [POS_W-1:0]  w_pos_inc;
    logic [POS_W-1:0]  w_len;
    logic              w_hdr_done;
    logic              w_pay_byte;

    assign o_cfg_ready = 1'b1;
    // The result register frees up in the same cycle it is drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_is_sync = (i_rx_byte == r_sync);
    assign w_pos_inc = r_pos + POS_W'(1);
    assign w_len     = {r_len_hi, r_len_lo};

    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_len_lo       = r_len_lo;
        n_len_hi       = r_len_hi;
        n_out_valid    = 1'b0;
        n_byte_valid   = 1'b0;
        n_data_byte    = '0;
        n_byte_offset  = '0;
        n_last         = 1'b0;
        n_aborted      = 1'b0;
        n_overrun      = 1'b0;
        n_frame_length = '0;
        w_hdr_done     = 1'b0;
        w_pay_byte     = 1'b0;

        if (i_command) begin
            n_phase = PH_HUNT;
            n_pos   = '0;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_is_sync) begin
                        n_phase = PH_HEADER;
                        n_pos   = '0;
                    end
                end
                PH_HEADER: begin
                    if (r_pos < POS_W'(HEADER_BYTES)) begin
                        if (r_pos[0]) begin
                            n_len_hi = i_rx_byte;
                        end else begin
                            n_len_lo = i_rx_byte;
                        end
                    end
                    if (w_is_sync) begin
                        n_phase = PH_HEADER_SYNC;
                    end else begin
                        n_pos = w_pos_inc;
                        w_hdr_done = (w_pos_inc >= POS_W'(HEADER_BYTES));
                    end
                end
                PH_HEADER_SYNC: begin
                    if (w_is_sync) begin
                        n_pos   = w_pos_inc;
                        n_phase = PH_HEADER;
                        w_hdr_done = (w_pos_inc >= POS_W'(HEADER_BYTES));
                    end
                end
                PH_PAYLOAD: begin
                    if (w_is_sync) begin
                        n_phase = PH_PAYLOAD_SYNC;
                    end else begin
                        w_pay_byte = 1'b1;
                    end
                end
                PH_PAYLOAD_SYNC: begin
                    w_pay_byte = w_is_sync;
                end
                default: begin
                    // Completed or overrun: bytes are dropped until rearm.
                end
            endcase

            // A lone sync in header or payload aborts and restarts the header.
            if ((r_phase == PH_HEADER_SYNC || r_phase == PH_PAYLOAD_SYNC) && !w_is_sync) begin
                n_len_lo    = i_rx_byte;
                n_pos       = POS_W'(1);
                n_phase     = PH_HEADER;
                n_out_valid = 1'b1;
                n_aborted   = 1'b1;
            end

            if (w_hdr_done) begin
                n_pos = '0;
                if ({n_len_hi, n_len_lo} == '0) begin
                    n_phase     = PH_COMPLETE;
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                end else if (r_capacity == '0) begin
                    n_phase        = PH_OVERRUN;
                    n_out_valid    = 1'b1;
                    n_overrun      = 1'b1;
                    n_frame_length = r_capacity;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end

            if (w_pay_byte) begin
                n_pos          = w_pos_inc;
                n_out_valid    = 1'b1;
                n_byte_valid   = 1'b1;
                n_data_byte    = i_rx_byte;
                n_byte_offset  = r_pos;
                n_frame_length = w_len;
                priority if (w_pos_inc == w_len) begin
                    n_phase = PH_COMPLETE;
                    n_last  = 1'b1;
                end else if (w_pos_inc >= r_capacity) begin
                    n_phase        = PH_OVERRUN;
                    n_overrun      = 1'b1;
                    n_frame_length = r_capacity;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync      <= SYNC_RESET;
            r_capacity  <= CAPACITY_RESET;
            r_phase     <= PH_HUNT;
            r_pos       <= '0;
            r_len_lo    <= '0;
            r_len_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SYNC_VALUE:       r_sync     <= i_cfg_data[BYTE_W-1:0];
                    CFG_PAYLOAD_CAPACITY: r_capacity <= i_cfg_data;
                    default:              r_sync     <= r_sync;
                endcase
            end
            if (w_in_acc) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_len_lo    <= n_len_lo;
                r_len_hi    <= n_len_hi;
                r_out_valid <= n_out_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte_valid   <= n_byte_valid;
            r_data_byte    <= n_data_byte;
            r_byte_offset  <= n_byte_offset;
            r_last         <= n_last;
            r_aborted      <= n_aborted;
            r_overrun      <= n_overrun;
            r_frame_length <= n_frame_length;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_valid   = r_byte_valid;
    assign o_data_byte    = r_data_byte;
    assign o_byte_offset  = r_byte_offset;
    assign o_last         = r_last;
    assign o_aborted      = r_aborted;
    assign o_overrun      = r_overrun;
    assign o_frame_length = r_frame_length;

endmodule

// ===== design/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the result channel of the sync stuffed frame decoder.
// ----------------------------------------------------------------------------
module sfd_checker
    import sfd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_byte_valid,
    input logic [BYTE_W-1:0] o_data_byte,
    input logic [POS_W-1:0]  o_byte_offset,
    input logic              o_last,
    input logic              o_aborted,
    input logic              o_overrun,
    input logic [POS_W-1:0]  o_frame_length
);

    // A pending result transaction is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_last)
            && $stable(o_byte_offset) && $stable(o_data_byte))
        else $error("result transaction dropped or changed while stalled");

    // Without a payload byte, data and offset read as zero.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_data_byte == '0 && o_byte_offset == '0)
        else $error("data or offset set on a result without a payload byte");

    // An abort carries nothing else.
    a_abort_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_aborted |-> !o_byte_valid && !o_last && !o_overrun
            && o_frame_length == '0)
        else $error("abort result carries other flags");

    // A frame cannot both complete and overrun.
    a_last_or_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_last && o_overrun))
        else $error("last and overrun set together");

    // A result without a byte is always a header event: abort, empty frame or overrun.
    a_event_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> $onehot({o_aborted, o_last, o_overrun}))
        else $error("result without payload byte has no event flag");

endmodule

bind sync_stuffed_frame_decoder sfd_checker u_sfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_byte_valid   (o_byte_valid),
    .o_data_byte    (o_data_byte),
    .o_byte_offset  (o_byte_offset),
    .o_last         (o_last),
    .o_aborted      (o_aborted),
    .o_overrun      (o_overrun),
    .o_frame_length (o_frame_length)
);
